/* sv/arc4_pkg.sv */
`default_nettype none
package arc4_pkg;

	localparam int KEY_MAX = 128;
	localparam int KEY_AW  = $clog2(KEY_MAX);
	localparam int KEY_CW  = $clog2(KEY_MAX + 1);
	localparam int CFG_W   = 21;

	localparam logic [11:0] DISCARD_RESET = 12'd1024;
	localparam logic [20:0] BUDGET_RESET  = 21'd1600000;

	// request codes
	localparam logic [1:0] REQ_RESET = 2'd0;
	localparam logic [1:0] REQ_KEY   = 2'd1;
	localparam logic [1:0] REQ_WORD  = 2'd2;
	localparam logic [1:0] REQ_UNIF  = 2'd3;

	// configuration register indexes
	localparam logic CFG_DISCARD = 1'b0;
	localparam logic CFG_RESEED  = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  key_byte;
		logic        last_key;
		logic [31:0] bound;
	} arc4_req_t;

	typedef struct packed {
		logic [31:0] word;
		logic        reseed_due;
	} arc4_rsp_t;

	typedef enum logic [3:0] {
		ST_SWEEP, ST_IDLE,
		ST_MIX0, ST_MIX1, ST_MIX2, ST_MIX3,
		ST_BYTE0, ST_BYTE1, ST_BYTE2, ST_BYTE3,
		ST_LOW, ST_MOD
	} arc4_state_t;

	typedef enum logic [1:0] {
		MODE_DISCARD, MODE_PLAIN, MODE_UNIF
	} arc4_mode_t;

	// budget after one word, saturating at zero
	function automatic logic [20:0] budget_dec(input logic [20:0] b);
		budget_dec = (b >= 21'd4) ? b - 21'd4 : 21'd0;
	endfunction

endpackage
`default_nettype wire

/* sv/arc4_rem.sv */
`default_nettype none
// Serial remainder: one quotient bit per cycle.
module arc4_rem import arc4_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      rem
);
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [32:0] trial;

	assign trial = {rem_q, dvd_q[31]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring step
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, dvs_q})
				rem_q <= 32'(trial - {1'b0, dvs_q});
			else
				rem_q <= trial[31:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

/* sv/arc4_keystream_generator.sv */
// A uniform draw with a nonzero bound makes two serial remainder passes and redraws while a word falls below the floor.
// Each keystream byte steps through ST_BYTE0..ST_BYTE3 and each mixing step through ST_MIX0..ST_MIX3 on the permutation
// memory, which has one write and one read port. One request at a time: busy is high while it runs, a new one is taken
// once it drops. Results are strobed by done for one cycle; the receiver cannot stall.
// After arst_n an identity fill of the permutation memory runs with busy high.
`default_nettype none
module arc4_keystream_generator import arc4_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire arc4_req_t        req,
	output logic                  done,
	output arc4_rsp_t             rsp,
	input  wire logic             cfg_we,
	input  wire logic             cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata
);
	arc4_state_t state_q, state_d;
	arc4_mode_t  mode_q;

	logic [7:0]  perm_mem [256];
	logic [7:0]  key_mem [KEY_MAX];
	logic        pwe;
	logic [7:0]  pwa, pwd, pra, prd;
	logic [7:0]  key_rd;

	logic [11:0] discard_q;
	logic [20:0] reseed_q;
	logic [20:0] budget_q;
	logic [7:0]  i_q, j_q, a_q, b_q, t_q, ptr_q, n_q;
	logic [KEY_CW-1:0] kc_q, len_q;
	logic [KEY_AW-1:0] kidx_q;
	logic [11:0] disc_q;
	logic [1:0]  bcnt_q;
	logic [31:0] word_q, low_q, bound_q, out_q;
	logic        sweep_rsp_q, done_q;
	logic        accept;
	logic [7:0]  byte_out;
	logic [31:0] word_full;
	logic [7:0]  jn;
	logic        rem_start, rem_done;
	logic [31:0] rem_dvd, rem_dvs, rem_val;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign byte_out  = (t_q == j_q) ? a_q : ((t_q == i_q) ? b_q : prd);
	assign word_full = {word_q[23:0], byte_out};
	assign jn        = j_q + prd + key_rd;

	// permutation and key memories
	always_ff @(posedge clk) begin
		if (pwe)
			perm_mem[pwa] <= pwd;
		prd <= perm_mem[pra];
		if (accept && req.req_type == REQ_KEY && kc_q < KEY_CW'(KEY_MAX))
			key_mem[kc_q[KEY_AW-1:0]] <= req.key_byte;
		key_rd <= key_mem[kidx_q];
	end

	arc4_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dvd),
		.divisor  (rem_dvs),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		pwe       = 1'b0;
		pwa       = i_q;
		pwd       = prd;
		pra       = i_q;
		rem_start = 1'b0;
		rem_dvd   = 32'd0 - bound_q;
		rem_dvs   = bound_q;
		case (state_q)
			ST_SWEEP: begin
				pwe = 1'b1;
				pwa = ptr_q;
				pwd = ptr_q;
				if (ptr_q == 8'hff)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_RESET: state_d = ST_SWEEP;
						REQ_KEY:   state_d = req.last_key ? ST_MIX0 : ST_IDLE;
						REQ_WORD:  state_d = ST_BYTE0;
						default:   state_d = (req.bound == 32'd0) ? ST_BYTE0 : ST_LOW;
					endcase
				end
			end
			ST_MIX0: begin
				pra     = i_q;
				state_d = ST_MIX1;
			end
			ST_MIX1: begin
				pra     = jn;
				state_d = ST_MIX2;
			end
			ST_MIX2: begin
				pwe     = 1'b1;
				pwa     = i_q;
				pwd     = prd;
				state_d = ST_MIX3;
			end
			ST_MIX3: begin
				pwe = 1'b1;
				pwa = j_q;
				pwd = a_q;
				if (n_q != 8'hff)
					state_d = ST_MIX0;
				else if (discard_q == 12'd0)
					state_d = ST_IDLE;
				else
					state_d = ST_BYTE0;
			end
			ST_BYTE0: begin
				pra     = i_q + 8'd1;
				state_d = ST_BYTE1;
			end
			ST_BYTE1: begin
				pra     = j_q;
				state_d = ST_BYTE2;
			end
			ST_BYTE2: begin
				pwe     = 1'b1;
				pwa     = i_q;
				pwd     = prd;
				pra     = a_q + prd;
				state_d = ST_BYTE3;
			end
			ST_BYTE3: begin
				pwe     = 1'b1;
				pwa     = j_q;
				pwd     = a_q;
				rem_dvd = word_full;
				if (mode_q == MODE_DISCARD) begin
					state_d = (disc_q == 12'd1) ? ST_IDLE : ST_BYTE0;
				end else if (bcnt_q != 2'd3) begin
					state_d = ST_BYTE0;
				end else if (mode_q == MODE_PLAIN) begin
					state_d = ST_IDLE;
				end else if (word_full < low_q) begin
					state_d = ST_BYTE0;
				end else begin
					rem_start = 1'b1;
					state_d   = ST_MOD;
				end
			end
			ST_LOW: begin
				if (rem_done)
					state_d = ST_BYTE0;
			end
			ST_MOD: begin
				if (rem_done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && accept && req.req_type == REQ_UNIF && req.bound != 32'd0)
			rem_start = 1'b1;
		// the bound register loads on this same edge, so take it from the request
		if (state_q == ST_IDLE) begin
			rem_dvd = 32'd0 - req.bound;
			rem_dvs = req.bound;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_SWEEP;
		else
			state_q <= state_d;
	end

	// control registers and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q   <= DISCARD_RESET;
			reseed_q    <= BUDGET_RESET;
			budget_q    <= '0;
			i_q         <= '0;
			j_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			t_q         <= '0;
			n_q         <= '0;
			kc_q        <= '0;
			len_q       <= '0;
			kidx_q      <= '0;
			disc_q      <= '0;
			bcnt_q      <= '0;
			word_q      <= '0;
			low_q       <= '0;
			bound_q     <= '0;
			out_q       <= '0;
			ptr_q       <= '0;
			sweep_rsp_q <= 1'b0;
			done_q      <= 1'b0;
			mode_q      <= MODE_PLAIN;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == CFG_DISCARD)
					discard_q <= cfg_wdata[11:0];
				else
					reseed_q <= cfg_wdata[20:0];
			end
			case (state_q)
				ST_SWEEP: begin
					ptr_q <= ptr_q + 8'd1;
					if (ptr_q == 8'hff) begin
						done_q      <= sweep_rsp_q;
						sweep_rsp_q <= 1'b0;
						out_q       <= '0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						bound_q <= req.bound;
						bcnt_q  <= '0;
						out_q   <= '0;
						case (req.req_type)
							REQ_RESET: begin
								i_q         <= '0;
								j_q         <= '0;
								kc_q        <= '0;
								budget_q    <= '0;
								ptr_q       <= '0;
								sweep_rsp_q <= 1'b1;
							end
							REQ_KEY: begin
								if (req.last_key) begin
									len_q  <= (kc_q < KEY_CW'(KEY_MAX)) ?
										kc_q + KEY_CW'(1) : kc_q;
									kidx_q <= '0;
									n_q    <= '0;
									kc_q   <= '0;
								end else begin
									done_q <= 1'b1;
									if (kc_q < KEY_CW'(KEY_MAX))
										kc_q <= kc_q + KEY_CW'(1);
								end
							end
							REQ_WORD: begin
								mode_q   <= MODE_PLAIN;
								budget_q <= budget_dec(budget_q);
							end
							default: begin
								if (req.bound == 32'd0) begin
									mode_q   <= MODE_PLAIN;
									budget_q <= budget_dec(budget_q);
								end else begin
									mode_q <= MODE_UNIF;
								end
							end
						endcase
					end
				end
				ST_MIX1: begin
					a_q <= prd;
					j_q <= jn;
				end
				ST_MIX3: begin
					n_q <= n_q + 8'd1;
					kidx_q <= ({1'b0, kidx_q} + KEY_CW'(1) == len_q) ?
						'0 : kidx_q + KEY_AW'(1);
					if (n_q == 8'hff) begin
						j_q    <= i_q;
						disc_q <= discard_q;
						mode_q <= MODE_DISCARD;
						if (discard_q == 12'd0) begin
							budget_q <= reseed_q;
							done_q   <= 1'b1;
						end
					end else begin
						i_q <= i_q + 8'd1;
					end
				end
				ST_BYTE0: begin
					i_q <= i_q + 8'd1;
					j_q <= j_q + 8'd1;
				end
				ST_BYTE1: begin
					a_q <= prd;
				end
				ST_BYTE2: begin
					b_q <= prd;
					t_q <= a_q + prd;
				end
				ST_BYTE3: begin
					word_q <= word_full;
					bcnt_q <= bcnt_q + 2'd1;
					disc_q <= disc_q - 12'd1;
					if (mode_q == MODE_DISCARD) begin
						if (disc_q == 12'd1) begin
							budget_q <= reseed_q;
							done_q   <= 1'b1;
						end
					end else if (bcnt_q == 2'd3) begin
						if (mode_q == MODE_PLAIN) begin
							out_q  <= word_full;
							done_q <= 1'b1;
						end else if (word_full < low_q) begin
							budget_q <= budget_dec(budget_q);
						end
					end
				end
				ST_LOW: begin
					if (rem_done) begin
						low_q    <= rem_val;
						budget_q <= budget_dec(budget_q);
					end
				end
				ST_MOD: begin
					if (rem_done) begin
						out_q  <= rem_val;
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign done            = done_q;
	assign rsp.word        = out_q;
	assign rsp.reseed_due  = (budget_q == 21'd0);

	// a result only follows a request taken or in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a running request");

	// the permutation memory is never written while idle
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pwe)
		else $error("permutation write while idle");

	// after the last mixing step j equals i
	a_mix_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX3 && n_q == 8'hff) |=> (j_q == i_q))
		else $error("j not aligned to i after mixing");

	// the divider starts only from idle or at a finished word
	a_rem_start: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> (state_q == ST_IDLE || state_q == ST_BYTE3))
		else $error("remainder unit started out of sequence");
endmodule
`default_nettype wire

/* tb/arc4_keystream_generator_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module arc4_keystream_generator_tb import arc4_pkg::*;;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	arc4_req_t        req;
	logic             done;
	arc4_rsp_t        rsp;
	logic             cfg_we;
	logic             cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	arc4_keystream_generator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	localparam longint CYCLE_LIMIT = 64'd20_000_000;

	// predictor state
	logic [7:0]  sbox [256];
	logic [7:0]  si, sj;
	logic [7:0]  key_mem [KEY_MAX];
	int          key_len;
	logic [20:0] budget;
	logic [11:0] discard_cfg;
	logic [20:0] reseed_cfg;

	arc4_rsp_t   rsp_queue[$];
	int          errors;
	longint      cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result check
	always @(posedge clk) begin
		arc4_rsp_t want;
		if (arst_n && done) begin
			if (rsp_queue.size() == 0) begin
				$error("unexpected result word=%h", rsp.word);
				errors++;
			end else begin
				want = rsp_queue.pop_front();
				if (rsp.word !== want.word) begin
					$error("word expected %h actual %h", want.word, rsp.word);
					errors++;
				end
				if (rsp.reseed_due !== want.reseed_due) begin
					$error("reseed_due expected %b actual %b", want.reseed_due,
						rsp.reseed_due);
					errors++;
				end
			end
		end
	end

	function automatic void sbox_identity();
		for (int k = 0; k < 256; k++) sbox[k] = 8'(k);
		si = 8'd0;
		sj = 8'd0;
	endfunction

	function automatic logic [7:0] stream_byte();
		logic [7:0] a, b;
		si = si + 8'd1;
		a = sbox[si];
		sj = sj + 8'd1;
		b = sbox[sj];
		sbox[si] = b;
		sbox[sj] = a;
		return sbox[8'(a + b)];
	endfunction

	function automatic logic [31:0] stream_word();
		logic [31:0] w;
		budget = (budget >= 21'd4) ? budget - 21'd4 : 21'd0;
		w = '0;
		for (int k = 0; k < 4; k++) w = {w[23:0], stream_byte()};
		return w;
	endfunction

	function automatic void key_schedule(int len);
		logic [7:0] a;
		si = si - 8'd1;
		for (int n = 0; n < 256; n++) begin
			si = si + 8'd1;
			a = sbox[si];
			sj = sj + a + key_mem[n % len];
			sbox[si] = sbox[sj];
			sbox[sj] = a;
		end
		sj = si;
		for (int n = 0; n < discard_cfg; n++) void'(stream_byte());
		budget = reseed_cfg;
	endfunction

	function automatic arc4_rsp_t predict_draw(arc4_req_t r);
		arc4_rsp_t o;
		logic [31:0] floor_val, w;
		o.word = '0;
		case (r.req_type)
			REQ_RESET: begin
				sbox_identity();
				key_len = 0;
				budget = '0;
			end
			REQ_KEY: begin
				if (key_len < KEY_MAX) begin
					key_mem[key_len] = r.key_byte;
					key_len++;
				end
				if (r.last_key) begin
					key_schedule(key_len);
					key_len = 0;
				end
			end
			REQ_WORD: o.word = stream_word();
			default: begin
				if (r.bound == 0) o.word = stream_word();
				else begin
					floor_val = (32'd0 - r.bound) % r.bound;
					do w = stream_word(); while (w < floor_val);
					o.word = w % r.bound;
				end
			end
		endcase
		o.reseed_due = (budget == 0);
		return o;
	endfunction

	// one transfer; fixed carries a hand-typed expectation when check_fixed
	task automatic send_req(arc4_req_t r, bit check_fixed = 0,
			arc4_rsp_t fixed = '0);
		arc4_rsp_t p;
		start = 1'b1;
		req   = r;
		do @(posedge clk); while (busy);
		p = predict_draw(r);
		if (check_fixed && p !== fixed) begin
			$error("table row expected %h/%b predictor %h/%b", fixed.word,
				fixed.reseed_due, p.word, p.reseed_due);
			errors++;
		end
		rsp_queue.push_back(p);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		while (rsp_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_DISCARD) discard_cfg = val[11:0];
		else reseed_cfg = val[20:0];
	endtask

	function automatic arc4_req_t mk(logic [1:0] t, logic [7:0] kb, logic lk,
			logic [31:0] bd);
		arc4_req_t r;
		r.req_type = t;
		r.key_byte = kb;
		r.last_key = lk;
		r.bound    = bd;
		return r;
	endfunction

	// random key: mostly short, sometimes over KEY_MAX; cnt counts the transfers
	task automatic random_key(inout int cnt);
		int len;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 140)
			: $urandom_range(1, 16);
		for (int k = 0; k < len; k++) begin
			send_req(mk(REQ_KEY, 8'($urandom), k == len - 1, $urandom));
			gap();
		end
		cnt += len;
	endtask

	typedef struct {
		arc4_req_t r;
		bit        fixed;
		arc4_rsp_t o;
	} stim_row_t;

	stim_row_t table_rows[$];
	int sent;
	int burst;

	initial begin
		errors = 0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_DISCARD;
		cfg_wdata = '0;
		arst_n = 1'b0;
		sbox_identity();
		key_len = 0;
		budget = '0;
		discard_cfg = DISCARD_RESET;
		reseed_cfg = BUDGET_RESET;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed rows: the reset row, the first key rows and the draw with bound 1 carry hand-typed expectations
		table_rows = '{
			'{mk(REQ_WORD, 8'h00, 1'b0, 32'h0), 1'b0, '0},
			'{mk(REQ_RESET, 8'hff, 1'b1, 32'hffffffff), 1'b1, '{32'h0, 1'b1}},
			'{mk(REQ_KEY, 8'h00, 1'b0, 32'h0), 1'b1, '{32'h0, 1'b1}},
			'{mk(REQ_KEY, 8'hff, 1'b0, 32'hffffffff), 1'b1, '{32'h0, 1'b1}},
			'{mk(REQ_KEY, 8'h5a, 1'b1, 32'h0), 1'b0, '0},
			'{mk(REQ_WORD, 8'h00, 1'b0, 32'h0), 1'b0, '0},
			'{mk(REQ_UNIF, 8'h00, 1'b0, 32'h0), 1'b0, '0},
			'{mk(REQ_UNIF, 8'h00, 1'b0, 32'h1), 1'b1, '{32'h0, 1'b0}},
			'{mk(REQ_UNIF, 8'h00, 1'b0, 32'h3), 1'b0, '0},
			'{mk(REQ_UNIF, 8'h00, 1'b0, 32'h80000001), 1'b0, '0},
			'{mk(REQ_UNIF, 8'hff, 1'b1, 32'hffffffff), 1'b0, '0},
			'{mk(REQ_UNIF, 8'h00, 1'b0, 32'hc0000000), 1'b0, '0}
		};
		foreach (table_rows[k]) send_req(table_rows[k].r, table_rows[k].fixed,
			table_rows[k].o);
		drain();

		// exhausted budget, no discard, overlong key
		write_cfg(CFG_DISCARD, 21'd0);
		write_cfg(CFG_RESEED, 21'd5);
		for (int k = 0; k < 130; k++)
			send_req(mk(REQ_KEY, 8'(k * 7), k == 129, 32'h0));
		repeat (3) send_req(mk(REQ_WORD, 8'h00, 1'b0, 32'h0));
		drain();

		// random phases over several register settings, extremes included
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_cfg(CFG_DISCARD, 21'd4095);
					write_cfg(CFG_RESEED, 21'h1fffff); end
				1: begin write_cfg(CFG_DISCARD, 21'd0);
					write_cfg(CFG_RESEED, 21'd0); end
				default: begin write_cfg(CFG_DISCARD, 21'($urandom_range(0, 64)));
					write_cfg(CFG_RESEED, 21'($urandom_range(0, 400))); end
			endcase
			while (sent < (ph + 1) * 240) begin
				burst = $urandom_range(1, 20);
				case ($urandom_range(0, 9))
					0: begin
						send_req(mk(REQ_RESET, 8'($urandom), 1'($urandom), $urandom));
						sent++;
					end
					1: random_key(sent);
					default: repeat (burst) begin
						send_req(mk($urandom_range(0, 1) ? REQ_WORD : REQ_UNIF,
							8'($urandom), 1'($urandom),
							$urandom_range(0, 2) == 0 ? $urandom
							: ($urandom_range(0, 1) ? 32'($urandom_range(0, 300))
							: ~32'($urandom_range(0, 300)))));
						sent++;
					end
				endcase
				repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 30))
					@(negedge clk);
			end
			drain();
		end

		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
